FILE: rtl/eps_pkg.sv
package eps_pkg;

  // Coordinate width: signed fixed point, Q16.16 at 32 bits
  localparam int COORD_BITS = 32;
  // Magnitude of a difference of two coordinates fits in COORD_BITS unsigned bits
  localparam int MAG_W      = COORD_BITS;
  localparam int PROD_W     = 2 * MAG_W;
  // One quotient bit per divider stage
  localparam int DIV_STAGES = MAG_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic        [COORD_BITS:0]   diff_t;

  // Input word: one mesh edge
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    logic   face_done;
  } edge_t;

  // Output word: plane crossing
  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
    logic   face_end;
  } cross_t;

  // Divider lane: partial remainder and dividend bits that shift out while
  // quotient bits shift in
  typedef struct packed {
    mag_t rem;
    mag_t lq;
  } lane_t;

  // Item as it travels through the divider stages
  typedef struct packed {
    logic   hit;
    logic   face_end;
    logic   neg_x;
    logic   neg_y;
    coord_t x0;
    coord_t y0;
    mag_t   den;
    lane_t  lane_x;
    lane_t  lane_y;
  } div_t;

  // Absolute value of a widened difference
  function automatic mag_t mag_of(diff_t v);
    diff_t n;
    n = v[COORD_BITS] ? (~v + diff_t'(1)) : v;
    return n[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/eps_if.sv
// Edge channel
interface eps_edge_if;
  import eps_pkg::*;
  logic  valid;
  logic  ready;
  edge_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Crossing channel
interface eps_cross_if;
  import eps_pkg::*;
  logic   valid;
  logic   ready;
  cross_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/edge_plane_slice_intersect.sv
// Edge / plane slicer.
// edge_i takes one mesh edge per word (two endpoints, signed Q16.16, and an
// end-of-face mark); cross_o gives one word per edge: hit flag, the crossing
// point x,y (zero on no hit) and the end-of-face mark, in input order.
// Both channels use valid/ready; a word moves when both are high.
// cfg_we_i writes cfg_data_i into the plane height; write it only while no
// edge is in flight.
// Throughput: one edge per cycle while the skid stage is free. From accept
// to cross_o.valid an edge passes one stage for differences and the
// plane test, one for the two products, one divider stage per quotient bit
// for both lanes, and the output register.
// Reset clears all valid bits and sets the plane height to zero.
// When cross_o stalls, the pipeline keeps taking edges until the skid stage
// behind the output register fills; then the whole pipeline holds and
// edge_i.ready drops until the output word is taken.
module edge_plane_slice_intersect
  import eps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  coord_t      cfg_data_i,
  eps_edge_if.sink    edge_i,
  eps_cross_if.source cross_o
);

  coord_t height_q;
  logic   adv;
  logic   vld [DIV_STAGES+1];
  div_t   div [DIV_STAGES+1];

  // Plane height register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
    end else if (cfg_we_i) begin
      height_q <= cfg_data_i;
    end
  end

  assign edge_i.ready = adv;

  eps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (edge_i.valid),
    .edge_i   (edge_i.data),
    .height_i (height_q),
    .vld_o    (vld[0]),
    .div_o    (div[0])
  );

  // Divider: one quotient bit per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    eps_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (vld[g]),
      .div_i  (div[g]),
      .vld_o  (vld[g+1]),
      .div_o  (div[g+1])
    );
  end

  eps_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld[DIV_STAGES]),
    .div_i   (div[DIV_STAGES]),
    .adv_o   (adv),
    .cross_o (cross_o)
  );

endmodule

FILE: rtl/eps_front.sv
module eps_front
  import eps_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   vld_i,
  input  edge_t  edge_i,
  input  coord_t height_i,
  output logic   vld_o,
  output div_t   div_o
);

  typedef struct packed {
    logic   hit;
    logic   face_end;
    logic   neg_x;
    logic   neg_y;
    coord_t x0;
    coord_t y0;
    mag_t   num_mag;
    mag_t   den_mag;
    mag_t   dx_mag;
    mag_t   dy_mag;
  } prep_t;

  diff_t num_s, den_s, dx_s, dy_s;
  logic  below, above;
  prep_t prep_d, prep_q;
  logic  vld_a_q, vld_b_q;
  logic [PROD_W-1:0] prod_x, prod_y;
  div_t  div_d, div_q;

  // Stage A: differences, plane test, signs
  always_comb begin
    num_s = {height_i[COORD_BITS-1], height_i} - {edge_i.start_z[COORD_BITS-1], edge_i.start_z};
    den_s = {edge_i.end_z[COORD_BITS-1], edge_i.end_z}
          - {edge_i.start_z[COORD_BITS-1], edge_i.start_z};
    dx_s  = {edge_i.end_x[COORD_BITS-1], edge_i.end_x}
          - {edge_i.start_x[COORD_BITS-1], edge_i.start_x};
    dy_s  = {edge_i.end_y[COORD_BITS-1], edge_i.end_y}
          - {edge_i.start_y[COORD_BITS-1], edge_i.start_y};
    below = (edge_i.start_z < height_i) && (edge_i.end_z < height_i);
    above = (edge_i.start_z > height_i) && (edge_i.end_z > height_i);

    prep_d.hit      = !(below || above) && (edge_i.end_z != edge_i.start_z);
    prep_d.face_end = edge_i.face_done;
    prep_d.neg_x    = num_s[COORD_BITS] ^ dx_s[COORD_BITS] ^ den_s[COORD_BITS];
    prep_d.neg_y    = num_s[COORD_BITS] ^ dy_s[COORD_BITS] ^ den_s[COORD_BITS];
    prep_d.x0       = edge_i.start_x;
    prep_d.y0       = edge_i.start_y;
    prep_d.num_mag  = mag_of(num_s);
    prep_d.den_mag  = mag_of(den_s);
    prep_d.dx_mag   = mag_of(dx_s);
    prep_d.dy_mag   = mag_of(dy_s);
  end

  // Stage B: full-width products, split into divider start value
  always_comb begin
    prod_x = PROD_W'(prep_q.num_mag) * PROD_W'(prep_q.dx_mag);
    prod_y = PROD_W'(prep_q.num_mag) * PROD_W'(prep_q.dy_mag);

    div_d.hit        = prep_q.hit;
    div_d.face_end   = prep_q.face_end;
    div_d.neg_x      = prep_q.neg_x;
    div_d.neg_y      = prep_q.neg_y;
    div_d.x0         = prep_q.x0;
    div_d.y0         = prep_q.y0;
    div_d.den        = prep_q.den_mag;
    div_d.lane_x.rem = prod_x[PROD_W-1:MAG_W];
    div_d.lane_x.lq  = prod_x[MAG_W-1:0];
    div_d.lane_y.rem = prod_y[PROD_W-1:MAG_W];
    div_d.lane_y.lq  = prod_y[MAG_W-1:0];
  end

  // Advance valid bits when the pipeline moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
      div_q  <= div_d;
    end
  end

  assign vld_o = vld_b_q;
  assign div_o = div_q;

endmodule

FILE: rtl/eps_div_stage.sv
module eps_div_stage
  import eps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  div_t div_i,
  output logic vld_o,
  output div_t div_o
);

  // One restoring step: bring in the next dividend bit, try to subtract
  function automatic lane_t div_step(lane_t l, mag_t den);
    logic [MAG_W:0]   t;
    logic [MAG_W+1:0] diff;
    logic             ge;
    lane_t            r;
    t    = {l.rem, l.lq[MAG_W-1]};
    diff = {1'b0, t} - {2'b00, den};
    ge   = ~diff[MAG_W+1];
    r.rem = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
    r.lq  = {l.lq[MAG_W-2:0], ge};
    return r;
  endfunction

  div_t div_d;
  div_t div_q;
  logic vld_q;

  always_comb begin
    div_d        = div_i;
    div_d.lane_x = div_step(div_i.lane_x, div_i.den);
    div_d.lane_y = div_step(div_i.lane_y, div_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

FILE: rtl/eps_out.sv
module eps_out
  import eps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  div_t        div_i,
  output logic        adv_o,
  eps_cross_if.source cross_o
);

  coord_t qx_s, qy_s;
  cross_t res;
  cross_t out_d, out_q, skid_d, skid_q;
  logic   out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic   push, pop;

  // Apply sign to the quotient and offset from the start point
  always_comb begin
    qx_s = div_i.neg_x ? coord_t'(~div_i.lane_x.lq + mag_t'(1)) : coord_t'(div_i.lane_x.lq);
    qy_s = div_i.neg_y ? coord_t'(~div_i.lane_y.lq + mag_t'(1)) : coord_t'(div_i.lane_y.lq);
    res.hit      = div_i.hit;
    res.cross_x  = div_i.hit ? coord_t'(div_i.x0 + qx_s) : '0;
    res.cross_y  = div_i.hit ? coord_t'(div_i.y0 + qy_s) : '0;
    res.face_end = div_i.face_end;
  end

  // Pipeline moves whenever the skid stage is free
  assign adv_o = ~skid_vld_q;
  assign push  = adv_o & vld_i;
  assign pop   = out_vld_q & cross_o.ready;

  // Output register with skid stage behind it
  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end else begin
        out_d     = res;
        out_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign cross_o.valid = out_vld_q;
  assign cross_o.data  = out_q;

endmodule

FILE: rtl/eps_chk.sv
module eps_chk
  import eps_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input cross_t out_data_i
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("output word changed while stalled");

  // A miss reports the origin
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.hit |-> out_data_i.cross_x == '0 && out_data_i.cross_y == '0)
    else $error("miss with nonzero crossing point");

  // Input stalls only behind a stalled output word
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back-pressure");

endmodule

bind edge_plane_slice_intersect eps_chk u_eps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (edge_i.ready),
  .out_valid_i (cross_o.valid),
  .out_ready_i (cross_o.ready),
  .out_data_i  (cross_o.data)
);
